### rtl/core/wbsac_pkg.sv
`default_nettype none
package wbsac_pkg;

  localparam int DefAddrBits = 16;
  localparam int SetW        = 2;
  localparam int WayW        = 2;
  localparam int SlotW       = SetW + WayW;
  localparam int WordW       = 4;
  localparam int NumWays     = 1 << WayW;
  localparam int NumSlots    = 1 << SlotW;
  localparam int LineWords   = 1 << WordW;
  localparam int LineAw      = SlotW + WordW;
  localparam int LineDepth   = 1 << LineAw;
  localparam int SetLsb      = 6;
  localparam int TagLsb      = 8;

  localparam logic ActLoad  = 1'b0;
  localparam logic ActStore = 1'b1;

  // Work request handed from the front to the back
  typedef struct packed {
    logic             action;
    logic [3:0]       byte_enable;
    logic [31:0]      write_data;
    logic             hit;
    logic             wrote_back;
    logic [SlotW-1:0] slot;
  } cmd_t;

  localparam int CmdW = $bits(cmd_t);

  typedef enum logic [5:0] {
    ST_CLR  = 6'b000001,
    ST_IDLE = 6'b000010,
    ST_WB   = 6'b000100,
    ST_FILL = 6'b001000,
    ST_RD   = 6'b010000,
    ST_MRG  = 6'b100000
  } back_state_t;

  function automatic logic [31:0] strobe_mask(input logic [3:0] be);
    logic [31:0] m;
    m = '0;
    for (int k = 0; k < 4; k++) begin
      m[8*k +: 8] = {8{be[k]}};
    end
    return m;
  endfunction

endpackage
`default_nettype wire

### rtl/core/wbsac_front.sv
`default_nettype none
module wbsac_front #(
  parameter int ADDR_BITS = wbsac_pkg::DefAddrBits
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         push,
  input  wire                         action,
  input  wire [ADDR_BITS-1:0]         address,
  input  wire [3:0]                   byte_enable,
  input  wire [31:0]                  write_data,
  output wbsac_pkg::cmd_t             cmd,
  output logic [ADDR_BITS-9:0]        victim_tag
);
  import wbsac_pkg::*;

  localparam int TagW = ADDR_BITS - TagLsb;

  logic [TagW-1:0] tag_q   [NumSlots];
  logic [NumSlots-1:0] valid_q;
  logic [NumSlots-1:0] dirty_q;
  logic [WayW-1:0] ptr_q   [1 << SetW];

  logic [SetW-1:0]  set_idx;
  logic [TagW-1:0]  req_tag;
  logic             found;
  logic [WayW-1:0]  hit_way;
  logic [WayW-1:0]  ptr_next;
  logic [SlotW-1:0] slot;

  assign set_idx  = address[SetLsb +: SetW];
  assign req_tag  = address[ADDR_BITS-1:TagLsb];
  assign ptr_next = ptr_q[set_idx] + WayW'(1);

  // tag compare over the set, first match wins
  always_comb begin
    found   = 1'b0;
    hit_way = '0;
    for (int w = 0; w < NumWays; w++) begin
      if (!found && valid_q[{set_idx, WayW'(w)}] && tag_q[{set_idx, WayW'(w)}] == req_tag) begin
        found   = 1'b1;
        hit_way = WayW'(w);
      end
    end
  end

  assign slot = found ? {set_idx, hit_way} : {set_idx, ptr_next};

  // classified request
  always_comb begin
    cmd.action      = action;
    cmd.byte_enable = byte_enable;
    cmd.write_data  = write_data;
    cmd.hit         = found;
    cmd.wrote_back  = !found && valid_q[slot] && dirty_q[slot];
    cmd.slot        = slot;
    victim_tag      = tag_q[slot];
  end

  // line state updated at classification time, back works in order
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= '0;
      dirty_q <= '0;
      for (int i = 0; i < NumSlots; i++) tag_q[i] <= '0;
      for (int i = 0; i < (1 << SetW); i++) ptr_q[i] <= '0;
    end else if (push) begin
      if (found) begin
        if (action == ActStore) dirty_q[slot] <= 1'b1;
      end else begin
        ptr_q[set_idx] <= ptr_next;
        tag_q[slot]    <= req_tag;
        valid_q[slot]  <= 1'b1;
        dirty_q[slot]  <= (action == ActStore);
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/wbsac_queue.sv
`default_nettype none
module wbsac_queue #(
  parameter int W = 8
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          push,
  input  wire [W-1:0]  push_data,
  output logic         not_full,
  input  wire          pop,
  output logic         not_empty,
  output logic [W-1:0] pop_data
);
  logic [W-1:0] entry [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign not_full  = (count != 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

### rtl/core/wbsac_back.sv
`default_nettype none
module wbsac_back #(
  parameter int ADDR_BITS = wbsac_pkg::DefAddrBits
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   q_valid,
  output logic                  q_pop,
  input  wbsac_pkg::cmd_t       q_cmd,
  input  wire [ADDR_BITS-1:0]   q_addr,
  input  wire [ADDR_BITS-9:0]   q_vtag,
  output logic                  clearing,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic [31:0]           read_data,
  output logic                  hit,
  output logic                  wrote_back,
  output logic [3:0]            line_slot
);
  import wbsac_pkg::*;

  localparam int TagW   = ADDR_BITS - TagLsb;
  localparam int MemAw  = ADDR_BITS - 2;
  localparam int MemDep = 1 << MemAw;

  back_state_t        state, state_next;
  cmd_t               cmd;
  logic [ADDR_BITS-1:0] addr;
  logic [TagW-1:0]    vtag;
  logic [WordW:0]     cnt;
  logic [MemAw-1:0]   clr_cnt;

  logic [31:0] line_mem [LineDepth];
  logic [31:0] back_mem [MemDep];
  logic [31:0] line_rd;
  logic [31:0] mem_rd;

  logic              l_re, l_we, m_re, m_we;
  logic [LineAw-1:0] l_ra, l_wa;
  logic [31:0]       l_wd, m_wd, merged, mask;
  logic [MemAw-1:0]  m_ra, m_wa;
  logic [WordW-1:0]  prev;
  logic              out_free;

  assign clearing = state == ST_CLR;
  assign prev     = cnt[WordW-1:0] - WordW'(1);
  assign mask     = strobe_mask(cmd.byte_enable);
  assign merged   = (cmd.action == ActStore) ? ((cmd.write_data & mask) | (line_rd & ~mask))
                                             : line_rd;
  assign out_free = !out_valid || out_ready;

  // sequencer: memory clear, write back, refill, word access
  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    l_re = 1'b0; l_we = 1'b0; m_re = 1'b0; m_we = 1'b0;
    l_ra = {cmd.slot, cnt[WordW-1:0]};
    l_wa = {cmd.slot, prev};
    l_wd = mem_rd;
    m_ra = {addr[ADDR_BITS-1:SetLsb], cnt[WordW-1:0]};
    m_wa = {vtag, addr[SetLsb +: SetW], prev};
    m_wd = line_rd;
    unique case (state)
      ST_CLR: begin
        m_we = 1'b1;
        m_wa = clr_cnt;
        m_wd = '0;
        if (&clr_cnt) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_cmd.hit)             state_next = ST_RD;
          else if (q_cmd.wrote_back) state_next = ST_WB;
          else                       state_next = ST_FILL;
        end
      end
      ST_WB: begin
        l_re = !cnt[WordW];
        m_we = cnt != '0;
        if (cnt[WordW]) state_next = ST_FILL;
      end
      ST_FILL: begin
        m_re = !cnt[WordW];
        l_we = cnt != '0;
        if (cnt[WordW]) state_next = ST_RD;
      end
      ST_RD: begin
        l_re = 1'b1;
        l_ra = {cmd.slot, addr[2 +: WordW]};
      end
      ST_MRG: begin
        if (out_free) begin
          l_we = cmd.action == ActStore;
          l_wa = {cmd.slot, addr[2 +: WordW]};
          l_wd = merged;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    if (state == ST_RD) state_next = ST_MRG;
  end

  // line data store
  always_ff @(posedge clk) begin
    if (l_we) line_mem[l_wa] <= l_wd;
    if (l_re) line_rd <= line_mem[l_ra];
  end

  // backing word memory
  always_ff @(posedge clk) begin
    if (m_we) back_mem[m_wa] <= m_wd;
    if (m_re) mem_rd <= back_mem[m_ra];
  end

  // request registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_valid) begin
      cmd  <= q_cmd;
      addr <= q_addr;
      vtag <= q_vtag;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == ST_MRG && out_free) begin
      read_data  <= merged;
      hit        <= cmd.hit;
      wrote_back <= cmd.wrote_back;
      line_slot  <= cmd.slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      cnt       <= '0;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLR) clr_cnt <= clr_cnt + MemAw'(1);
      if (state != state_next) cnt <= '0;
      else if (state == ST_WB || state == ST_FILL) cnt <= cnt + (WordW+1)'(1);
      if (state == ST_MRG && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

### rtl/core/write_back_set_assoc_cache_core.sv
// Hit: the back pops the request, reads the line word, then merges and registers the result.
// Miss: a dirty victim line is first written back, then the line is refilled, then as a hit.
// The back serves one request at a time, moving all 16 words on each write back and refill.
// Reset: line state and round-robin pointers clear at once; the backing memory is then
// swept to zero, one word a cycle, over all 2^(ADDR_BITS-2) words, while in_ready stays low.
`default_nettype none
module write_back_set_assoc_cache_core #(
  parameter int ADDR_BITS = wbsac_pkg::DefAddrBits
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire                  action,
  input  wire [ADDR_BITS-1:0]  address,
  input  wire [3:0]            byte_enable,
  input  wire [31:0]           write_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic [31:0]          read_data,
  output logic                 hit,
  output logic                 wrote_back,
  output logic [3:0]           line_slot
);
  import wbsac_pkg::*;

  localparam int TagW = ADDR_BITS - TagLsb;
  localparam int QW   = CmdW + ADDR_BITS + TagW;

  cmd_t            f_cmd, b_cmd;
  logic [TagW-1:0] f_vtag, b_vtag;
  logic [ADDR_BITS-1:0] b_addr;
  logic            push, q_not_full, q_not_empty, q_pop, clearing;
  logic [QW-1:0]   q_out;

  assign in_ready = q_not_full && !clearing;
  assign push     = in_valid && in_ready;

  wbsac_front #(.ADDR_BITS(ADDR_BITS)) u_front (
    .clk, .rst, .push, .action, .address, .byte_enable, .write_data,
    .cmd(f_cmd), .victim_tag(f_vtag)
  );

  wbsac_queue #(.W(QW)) u_queue (
    .clk, .rst, .push, .push_data({f_cmd, address, f_vtag}),
    .not_full(q_not_full), .pop(q_pop), .not_empty(q_not_empty), .pop_data(q_out)
  );

  assign {b_cmd, b_addr, b_vtag} = q_out;

  wbsac_back #(.ADDR_BITS(ADDR_BITS)) u_back (
    .clk, .rst, .q_valid(q_not_empty), .q_pop, .q_cmd(b_cmd), .q_addr(b_addr),
    .q_vtag(b_vtag), .clearing, .out_valid, .out_ready, .read_data, .hit,
    .wrote_back, .line_slot
  );

endmodule
`default_nettype wire
